// ===== rtl/core/metronome_beat_generator_macros.svh =====
// Assertion macros shared by the metronome beat generator RTL.
`ifndef METRONOME_BEAT_GENERATOR_MACROS_SVH
`define METRONOME_BEAT_GENERATOR_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked outside reset.
`define MBG_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mbg: same-cycle implication failed");

// Next-cycle implication, checked outside reset.
`define MBG_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mbg: next-cycle implication failed");

`else

`define MBG_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define MBG_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== rtl/core/mbg_pkg.sv =====
// Shared types, constants and helper functions for the metronome beat generator.
`default_nettype none

package mbg_pkg;

    localparam int NUM_W    = 16;
    localparam int SCAN_W   = 8;
    localparam int SAMPLE_W = 10;
    localparam int BPM_W    = 8;
    localparam int BEAT_W   = 3;
    localparam int LED_W    = 4;
    localparam int DIGSEL_W = 2;
    localparam int DIGIT_W  = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam int DIV_STEPS = NUM_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

    localparam logic [NUM_W-1:0]  ON_NUM_RESET      = 16'd6000;
    localparam logic [NUM_W-1:0]  OFF_NUM_RESET     = 16'd54000;
    localparam logic [SCAN_W-1:0] SCAN_PERIOD_RESET = 8'd7;
    localparam logic [BEAT_W-1:0] METER_MAX         = 3'd4;
    localparam logic [BEAT_W-1:0] METER_RESET       = 3'd4;
    localparam logic [NUM_W-1:0]  PHASE_MAX         = 16'hFFFF;
    localparam logic [BPM_W-1:0]  BPM_MIN           = 8'd40;
    localparam logic [10:0]       SAMPLE_FULL       = 11'd1023;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ON_NUM      = 2'd0,
        CFG_OFF_NUM     = 2'd1,
        CFG_SCAN_PERIOD = 2'd2
    } cfg_idx_t;

    typedef enum logic [DIGSEL_W-1:0] {
        DIG_HUNDREDS = 2'd0,
        DIG_TENS     = 2'd1,
        DIG_UNITS    = 2'd2
    } digsel_t;

    typedef enum logic {
        OP_TICK   = 1'b0,
        OP_BUTTON = 1'b1
    } op_t;

    // Controller to datapath commands.
    typedef struct packed {
        logic take_in;
        logic load_tempo;
        logic div_start;
        logic commit;
    } mbg_cmd_t;

    // Datapath to controller status.
    typedef struct packed {
        logic op_button;
        logic div_done;
    } mbg_sts_t;

    // bpm = 40 + (sample * 200) / 1023, the divide by 1023 done as
    // x/1024 plus a one-step correction (remainder stays below 2 * 1023).
    function automatic logic [BPM_W-1:0] tempo_from_sample(input logic [SAMPLE_W-1:0] s);
        logic [17:0] x;
        logic [7:0]  q0;
        logic [10:0] r;
        logic [7:0]  q;
        x  = {1'b0, s, 7'b0} + {2'b0, s, 6'b0} + {5'b0, s, 3'b0};
        q0 = x[17:10];
        r  = {1'b0, x[9:0]} + {3'b0, q0};
        q  = (r >= SAMPLE_FULL) ? q0 + 8'd1 : q0;
        return BPM_MIN + q;
    endfunction

    // Decimal digit of a bpm value (at most 255) at the given position.
    function automatic logic [DIGIT_W-1:0] bpm_digit(input logic [BPM_W-1:0] bpm,
                                                     input logic [DIGSEL_W-1:0] sel);
        logic [1:0]  h;
        logic [7:0]  rest;
        logic [14:0] prod;
        logic [3:0]  t;
        logic [6:0]  u;
        logic [DIGIT_W-1:0] d;
        if (bpm >= 8'd200) begin
            h    = 2'd2;
            rest = bpm - 8'd200;
        end else if (bpm >= 8'd100) begin
            h    = 2'd1;
            rest = bpm - 8'd100;
        end else begin
            h    = 2'd0;
            rest = bpm;
        end
        // rest < 100: tens = (rest * 205) >> 11
        prod = {8'b0, rest[6:0]} * 15'd205;
        t    = prod[14:11];
        u    = rest[6:0] - {3'b0, t} * 7'd10;
        unique case (sel)
            DIG_HUNDREDS: d = {2'b0, h};
            DIG_TENS:     d = t;
            default:      d = u[3:0];
        endcase
        return d;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/mbg_div.sv =====
// Radix-2 restoring divider: 16-bit dividend by 8-bit divisor, one bit per cycle.
`default_nettype none

module mbg_div
    import mbg_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             start,
    input  wire logic [NUM_W-1:0] dividend,
    input  wire logic [BPM_W-1:0] divisor,
    output logic      [NUM_W-1:0] quotient,
    output logic                  done
);

    logic [BPM_W:0]       rem_reg, rem_next;
    logic [NUM_W-1:0]     quo_reg, quo_next;
    logic [BPM_W-1:0]     dsr_reg, dsr_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;

    logic [BPM_W:0]   shifted;
    logic [BPM_W+1:0] trial;

    always_comb begin
        shifted   = {rem_reg[BPM_W-1:0], quo_reg[NUM_W-1]};
        trial     = {1'b0, shifted} - {2'b0, dsr_reg};
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = done_reg;
        if (start) begin
            rem_next  = '0;
            quo_next  = dividend;
            dsr_next  = divisor;
            cnt_next  = DIV_CNT_W'(DIV_STEPS);
            busy_next = 1'b1;
            done_next = 1'b0;
        end else if (busy_reg) begin
            // keep the trial difference when it does not go negative
            if (!trial[BPM_W+1]) begin
                rem_next = trial[BPM_W:0];
                quo_next = {quo_reg[NUM_W-2:0], 1'b1};
            end else begin
                rem_next = shifted;
                quo_next = {quo_reg[NUM_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == DIV_CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
        if (!aresetn) begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign quotient = quo_reg;
    assign done     = done_reg;

endmodule

`default_nettype wire

// ===== rtl/core/mbg_ctrl.sv =====
// Sequencing state machine: accept, tempo, divide (tick beats only), commit.
`default_nettype none

module mbg_ctrl
    import mbg_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     s_valid,
    output logic          s_ready,
    output logic          m_valid,
    input  wire logic     m_ready,
    output mbg_cmd_t      cmd,
    input  wire mbg_sts_t sts
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TEMPO,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_COMMIT
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;
    logic   out_free;

    always_comb begin
        out_free       = !m_valid_reg || m_ready;
        cmd.take_in    = (state_reg == ST_IDLE) && s_valid;
        cmd.load_tempo = (state_reg == ST_TEMPO);
        cmd.div_start  = (state_reg == ST_DIV_GO);
        cmd.commit     = (state_reg == ST_COMMIT) && out_free;

        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:     if (s_valid) state_next = ST_TEMPO;
            ST_TEMPO:    state_next = sts.op_button ? ST_COMMIT : ST_DIV_GO;
            ST_DIV_GO:   state_next = ST_DIV_WAIT;
            ST_DIV_WAIT: if (sts.div_done) state_next = ST_COMMIT;
            ST_COMMIT:   if (out_free) state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase

        m_valid_next = cmd.commit ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;

endmodule

`default_nettype wire

// ===== rtl/core/mbg_dp.sv =====
// Datapath: config registers, beat and scan state, divider and result register.
`default_nettype none

module mbg_dp
    import mbg_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire mbg_cmd_t              cmd,
    output mbg_sts_t                   sts,
    input  wire logic                  s_op,
    input  wire logic [SAMPLE_W-1:0]   s_tempo_sample,
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
    output logic                       m_buzzer_gate,
    output logic                       m_tone_start,
    output logic                       m_tone_accent,
    output logic [LED_W-1:0]           m_led_pattern,
    output logic [BEAT_W-1:0]          m_beat_number,
    output logic [BPM_W-1:0]           m_tempo_bpm,
    output logic [DIGSEL_W-1:0]        m_digit_select,
    output logic [DIGIT_W-1:0]         m_digit_value
);

    // configuration
    logic [NUM_W-1:0]  on_num_reg, off_num_reg;
    logic [SCAN_W-1:0] scan_period_reg;

    // beat and scan state
    logic [NUM_W-1:0]    phase_reg, phase_next;
    logic                gate_reg, gate_next;
    logic [BEAT_W-1:0]   beat_reg, beat_next;
    logic [BEAT_W-1:0]   meter_reg, meter_next;
    logic [LED_W-1:0]    led_reg, led_next;
    logic [SCAN_W-1:0]   scan_reg, scan_next;
    logic [DIGSEL_W-1:0] dig_reg, dig_next;

    // item payload
    logic                op_reg;
    logic [SAMPLE_W-1:0] sample_reg;
    logic [BPM_W-1:0]    bpm_reg;

    // result register
    logic                o_gate_reg, o_start_reg, o_accent_reg;
    logic [LED_W-1:0]    o_led_reg;
    logic [BEAT_W-1:0]   o_beat_reg;
    logic [BPM_W-1:0]    o_bpm_reg;
    logic [DIGSEL_W-1:0] o_dig_reg;
    logic [DIGIT_W-1:0]  o_digit_reg;

    logic [NUM_W-1:0]  div_q;
    logic              div_done;
    logic [NUM_W-1:0]  phase_inc;
    logic [SCAN_W-1:0] scan_inc, period;
    logic [BEAT_W-1:0] beat_inc;
    logic              start_flag, accent_flag;

    mbg_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (gate_reg ? on_num_reg : off_num_reg),
        .divisor  (bpm_reg),
        .quotient (div_q),
        .done     (div_done)
    );

    always_comb begin
        sts.op_button = (op_reg == OP_BUTTON);
        sts.div_done  = div_done;

        phase_inc = (phase_reg == PHASE_MAX) ? phase_reg : phase_reg + 1'b1;
        scan_inc  = scan_reg + 1'b1;
        period    = (scan_period_reg == '0) ? SCAN_W'(1) : scan_period_reg;
        beat_inc  = beat_reg + 1'b1;

        phase_next  = phase_reg;
        gate_next   = gate_reg;
        beat_next   = beat_reg;
        meter_next  = meter_reg;
        led_next    = led_reg;
        scan_next   = scan_reg;
        dig_next    = dig_reg;
        start_flag  = 1'b0;
        accent_flag = 1'b0;

        if (op_reg == OP_BUTTON) begin
            meter_next = (meter_reg >= METER_MAX) ? BEAT_W'(1) : meter_reg + 1'b1;
            beat_next  = '0;
        end else begin
            phase_next = phase_inc;
            if (gate_reg && phase_inc >= div_q) begin
                gate_next  = 1'b0;
                phase_next = '0;
            end else if (!gate_reg && phase_inc >= div_q) begin
                gate_next  = 1'b1;
                phase_next = '0;
                beat_next  = (beat_inc > meter_reg || beat_inc > METER_MAX) ?
                             BEAT_W'(1) : beat_inc;
                led_next   = LED_W'(1) << (beat_next - 1'b1);
                start_flag  = 1'b1;
                accent_flag = (beat_next == BEAT_W'(1));
            end
            scan_next = scan_inc;
            if (scan_inc >= period) begin
                scan_next = '0;
                dig_next  = (dig_reg >= DIG_UNITS) ? DIG_HUNDREDS : dig_reg + 1'b1;
            end
        end
    end

    // payload: no reset
    always_ff @(posedge aclk) begin
        if (cmd.take_in) begin
            op_reg     <= s_op;
            sample_reg <= s_tempo_sample;
        end
        if (cmd.load_tempo) begin
            bpm_reg <= tempo_from_sample(sample_reg);
        end
        if (cmd.commit) begin
            o_gate_reg   <= gate_next;
            o_start_reg  <= start_flag;
            o_accent_reg <= accent_flag;
            o_led_reg    <= led_next;
            o_beat_reg   <= beat_next;
            o_bpm_reg    <= bpm_reg;
            o_dig_reg    <= dig_next;
            o_digit_reg  <= bpm_digit(bpm_reg, dig_next);
        end
    end

    // configuration and beat state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            on_num_reg      <= ON_NUM_RESET;
            off_num_reg     <= OFF_NUM_RESET;
            scan_period_reg <= SCAN_PERIOD_RESET;
            phase_reg       <= '0;
            gate_reg        <= 1'b0;
            beat_reg        <= '0;
            meter_reg       <= METER_RESET;
            led_reg         <= '0;
            scan_reg        <= '0;
            dig_reg         <= DIG_HUNDREDS;
        end else begin
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    CFG_ON_NUM:      on_num_reg      <= cfg_wdata;
                    CFG_OFF_NUM:     off_num_reg     <= cfg_wdata;
                    CFG_SCAN_PERIOD: scan_period_reg <= cfg_wdata[SCAN_W-1:0];
                    default: ;
                endcase
            end
            if (cmd.commit) begin
                phase_reg <= phase_next;
                gate_reg  <= gate_next;
                beat_reg  <= beat_next;
                meter_reg <= meter_next;
                led_reg   <= led_next;
                scan_reg  <= scan_next;
                dig_reg   <= dig_next;
            end
        end
    end

    assign m_buzzer_gate  = o_gate_reg;
    assign m_tone_start   = o_start_reg;
    assign m_tone_accent  = o_accent_reg;
    assign m_led_pattern  = o_led_reg;
    assign m_beat_number  = o_beat_reg;
    assign m_tempo_bpm    = o_bpm_reg;
    assign m_digit_select = o_dig_reg;
    assign m_digit_value  = o_digit_reg;

endmodule

`default_nettype wire

// ===== rtl/core/metronome_beat_generator.sv =====
// Top level of the metronome beat generator: controller, datapath and checks.
//
//  channel  | handshake                | payload
//  ---------+--------------------------+-----------------------------------------------
//  input    | s_valid / s_ready        | s_op, s_tempo_sample
//  result   | m_valid / m_ready        | m_buzzer_gate .. m_digit_value (8 fields)
//  config   | cfg_wr_en (no wait)      | cfg_index, cfg_wdata
//
// A tick beat runs from acceptance through these steps in order: latch, map the
// sample to bpm, launch the divider, 16 divider iterations plus observing
// completion, and commit. The 16-step restoring divider that forms the phase
// length from the numerator sets the length of a tick beat. A button beat skips the divider.
// A stalled result holds the commit until the output register frees; the
// output register keeps the last result while the next item is latched and
// processed. Reset is synchronous, active low.
`default_nettype none
`include "metronome_beat_generator_macros.svh"

module metronome_beat_generator
    import mbg_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    // input beat
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire logic                  s_op,
    input  wire logic [SAMPLE_W-1:0]   s_tempo_sample,
    // result beat
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic                       m_buzzer_gate,
    output logic                       m_tone_start,
    output logic                       m_tone_accent,
    output logic [LED_W-1:0]           m_led_pattern,
    output logic [BEAT_W-1:0]          m_beat_number,
    output logic [BPM_W-1:0]           m_tempo_bpm,
    output logic [DIGSEL_W-1:0]        m_digit_select,
    output logic [DIGIT_W-1:0]         m_digit_value,
    // configuration writes
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

    mbg_cmd_t cmd;
    mbg_sts_t sts;

    // Sequence each beat: latch, tempo, divide (tick beats only), commit.
    mbg_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd),
        .sts     (sts)
    );

    // Hold config, beat and scan state; compute and register the result.
    mbg_dp u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .sts            (sts),
        .s_op           (s_op),
        .s_tempo_sample (s_tempo_sample),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .m_buzzer_gate  (m_buzzer_gate),
        .m_tone_start   (m_tone_start),
        .m_tone_accent  (m_tone_accent),
        .m_led_pattern  (m_led_pattern),
        .m_beat_number  (m_beat_number),
        .m_tempo_bpm    (m_tempo_bpm),
        .m_digit_select (m_digit_select),
        .m_digit_value  (m_digit_value)
    );

    // An accent only comes with a tone start.
    `MBG_ASSERT_IMPLY(a_accent_needs_start, aclk, aresetn, m_valid && m_tone_accent, m_tone_start)
    // A new beat always opens the on phase.
    `MBG_ASSERT_IMPLY(a_start_gate_on, aclk, aresetn, m_valid && m_tone_start, m_buzzer_gate)
    // At most one beat LED lights.
    `MBG_ASSERT_IMPLY(a_led_onehot0, aclk, aresetn, m_valid, $onehot0(m_led_pattern))
    // One item in flight: ready drops right after an accepted beat.
    `MBG_ASSERT_NEXT(a_one_in_flight, aclk, aresetn, s_valid && s_ready, !s_ready)

endmodule

`default_nettype wire
